// ===== hw/rtl/yuvp_pkg.sv =====
// yuvp_pkg: shared types and constants for the YUV pixel-pair to RGB888 block.
// No dependencies.

package yuvp_pkg;

    localparam int CHROMA_W  = 9;
    localparam int PROD_W    = 17;
    localparam int OFF_W     = 9;
    localparam int SUM_W     = 10;
    localparam int FRAC_BITS = 8;

    localparam logic [1:0] LAYOUT_YUYV = 2'd0;
    localparam logic [1:0] LAYOUT_UYVY = 2'd1;
    localparam logic [1:0] LAYOUT_NV12 = 2'd2;
    localparam logic [1:0] LAYOUT_NV21 = 2'd3;

    localparam logic signed [CHROMA_W-1:0] CHROMA_OFFSET = 9'sd128;
    localparam logic signed [9:0]          COEF_RV       = 10'sd359;
    localparam logic signed [9:0]          COEF_GU       = 10'sd88;
    localparam logic signed [9:0]          COEF_GV       = 10'sd183;
    localparam logic signed [9:0]          COEF_BU       = 10'sd454;
    localparam logic signed [SUM_W-1:0]    CHAN_MAX      = 10'sd255;

    typedef struct packed {
        logic [7:0] byte_first;
        logic [7:0] byte_second;
        logic [7:0] byte_third;
        logic [7:0] byte_fourth;
    } in_item_t;

    typedef struct packed {
        logic [7:0] red_left;
        logic [7:0] green_left;
        logic [7:0] blue_left;
        logic [7:0] red_right;
        logic [7:0] green_right;
        logic [7:0] blue_right;
    } out_item_t;

    typedef struct packed {
        logic mul;
        logic shift;
    } stage_en_t;

    typedef struct packed {
        logic signed [OFF_W-1:0] dr;
        logic signed [OFF_W-1:0] dg;
        logic signed [OFF_W-1:0] db;
    } chroma_off_t;

endpackage

// ===== hw/rtl/yuvp_chroma.sv =====
// yuvp_chroma: two-stage chroma term pipeline (multiply, then sum and floor shift).
// Depends on yuvp_pkg.

module yuvp_chroma (
    input  logic                                 aclk,
    input  yuvp_pkg::stage_en_t                  en,
    input  logic signed [yuvp_pkg::CHROMA_W-1:0] u,
    input  logic signed [yuvp_pkg::CHROMA_W-1:0] v,
    output yuvp_pkg::chroma_off_t                offs
);

    logic signed [yuvp_pkg::PROD_W-1:0] rv_reg, gu_reg, gv_reg, bu_reg;
    logic signed [yuvp_pkg::PROD_W-1:0] rv_next, gu_next, gv_next, bu_next;
    logic signed [yuvp_pkg::PROD_W-1:0] gsum;
    yuvp_pkg::chroma_off_t offs_reg, offs_next;

    always_comb begin
        rv_next = yuvp_pkg::PROD_W'(v) * yuvp_pkg::PROD_W'(yuvp_pkg::COEF_RV);
        gu_next = yuvp_pkg::PROD_W'(u) * yuvp_pkg::PROD_W'(yuvp_pkg::COEF_GU);
        gv_next = yuvp_pkg::PROD_W'(v) * yuvp_pkg::PROD_W'(yuvp_pkg::COEF_GV);
        bu_next = yuvp_pkg::PROD_W'(u) * yuvp_pkg::PROD_W'(yuvp_pkg::COEF_BU);
    end

    // arithmetic shift gives floor division by 256
    always_comb begin
        gsum         = gu_reg + gv_reg;
        offs_next.dr = yuvp_pkg::OFF_W'(rv_reg >>> yuvp_pkg::FRAC_BITS);
        offs_next.dg = yuvp_pkg::OFF_W'(gsum >>> yuvp_pkg::FRAC_BITS);
        offs_next.db = yuvp_pkg::OFF_W'(bu_reg >>> yuvp_pkg::FRAC_BITS);
    end

    always_ff @(posedge aclk) begin
        if (en.mul) begin
            rv_reg <= rv_next;
            gu_reg <= gu_next;
            gv_reg <= gv_next;
            bu_reg <= bu_next;
        end
        if (en.shift) begin
            offs_reg <= offs_next;
        end
    end

    assign offs = offs_reg;

endmodule

// ===== hw/rtl/yuv_pair_to_rgb888.sv =====
// yuv_pair_to_rgb888: top level, YUV 4:2:x pixel pair to two RGB888 pixels.
// Depends on yuvp_pkg and yuvp_chroma.

// Takes one pixel pair per clock while s_ready is high and returns two BT.601
// full-range RGB888 pixels for it. The four register stages (byte unpack,
// chroma multiply, term sum and shift, luma add and saturate) each carry a
// valid bit; a low m_ready stalls only as far back as needed to fill bubbles.
// Users must write pixel_layout via the cfg port only while idle (unenforced).

module yuv_pair_to_rgb888 (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  yuvp_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output yuvp_pkg::out_item_t m_data
);

    logic [1:0] pixel_layout_reg;

    logic st1_valid_reg, st2_valid_reg, st3_valid_reg, out_valid_reg;
    logic en1, en2, en3, out_en;

    logic [7:0] y0_next, y1_next, cu_byte, cv_byte;
    logic signed [yuvp_pkg::CHROMA_W-1:0] u_next, v_next, u1_reg, v1_reg;
    logic [7:0] y0_1_reg, y1_1_reg, y0_2_reg, y1_2_reg, y0_3_reg, y1_3_reg;

    yuvp_pkg::stage_en_t   ch_en;
    yuvp_pkg::chroma_off_t offs;
    yuvp_pkg::out_item_t   m_data_reg, m_data_next;

    function automatic logic [7:0] sat8(input logic signed [yuvp_pkg::SUM_W-1:0] s);
        logic [7:0] r;
        if (s < 0) begin
            r = 8'd0;
        end else if (s > yuvp_pkg::CHAN_MAX) begin
            r = 8'd255;
        end else begin
            r = s[7:0];
        end
        return r;
    endfunction

    function automatic logic [7:0] add_sat(input logic [7:0] y,
                                           input logic signed [yuvp_pkg::OFF_W-1:0] d);
        logic signed [yuvp_pkg::SUM_W-1:0] s;
        s = signed'({2'b00, y}) + yuvp_pkg::SUM_W'(d);
        return sat8(s);
    endfunction

    function automatic logic [7:0] sub_sat(input logic [7:0] y,
                                           input logic signed [yuvp_pkg::OFF_W-1:0] d);
        logic signed [yuvp_pkg::SUM_W-1:0] s;
        s = signed'({2'b00, y}) - yuvp_pkg::SUM_W'(d);
        return sat8(s);
    endfunction

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pixel_layout_reg <= yuvp_pkg::LAYOUT_YUYV;
        end else if (cfg_valid && cfg_ready) begin
            pixel_layout_reg <= cfg_data;
        end
    end

    // stall chain: a stage loads when empty or when the next stage loads
    assign out_en  = !out_valid_reg || m_ready;
    assign en3     = !st3_valid_reg || out_en;
    assign en2     = !st2_valid_reg || en3;
    assign en1     = !st1_valid_reg || en2;
    assign s_ready = en1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_valid_reg <= 1'b0;
            st2_valid_reg <= 1'b0;
            st3_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (en1) begin
                st1_valid_reg <= s_valid;
            end
            if (en2) begin
                st2_valid_reg <= st1_valid_reg;
            end
            if (en3) begin
                st3_valid_reg <= st2_valid_reg;
            end
            if (out_en) begin
                out_valid_reg <= st3_valid_reg;
            end
        end
    end

    always_comb begin
        case (pixel_layout_reg)
            yuvp_pkg::LAYOUT_YUYV: begin
                y0_next = s_data.byte_first;
                cu_byte = s_data.byte_second;
                y1_next = s_data.byte_third;
                cv_byte = s_data.byte_fourth;
            end
            yuvp_pkg::LAYOUT_UYVY: begin
                cu_byte = s_data.byte_first;
                y0_next = s_data.byte_second;
                cv_byte = s_data.byte_third;
                y1_next = s_data.byte_fourth;
            end
            yuvp_pkg::LAYOUT_NV12: begin
                y0_next = s_data.byte_first;
                y1_next = s_data.byte_second;
                cu_byte = s_data.byte_third;
                cv_byte = s_data.byte_fourth;
            end
            default: begin
                y0_next = s_data.byte_first;
                y1_next = s_data.byte_second;
                cv_byte = s_data.byte_third;
                cu_byte = s_data.byte_fourth;
            end
        endcase
        u_next = signed'({1'b0, cu_byte}) - yuvp_pkg::CHROMA_OFFSET;
        v_next = signed'({1'b0, cv_byte}) - yuvp_pkg::CHROMA_OFFSET;
    end

    always_ff @(posedge aclk) begin
        if (en1) begin
            y0_1_reg <= y0_next;
            y1_1_reg <= y1_next;
            u1_reg   <= u_next;
            v1_reg   <= v_next;
        end
        if (en2) begin
            y0_2_reg <= y0_1_reg;
            y1_2_reg <= y1_1_reg;
        end
        if (en3) begin
            y0_3_reg <= y0_2_reg;
            y1_3_reg <= y1_2_reg;
        end
        if (out_en) begin
            m_data_reg <= m_data_next;
        end
    end

    assign ch_en.mul   = en2;
    assign ch_en.shift = en3;

    yuvp_chroma u_chroma (
        .aclk (aclk),
        .en   (ch_en),
        .u    (u1_reg),
        .v    (v1_reg),
        .offs (offs)
    );

    always_comb begin
        m_data_next.red_left    = add_sat(y0_3_reg, offs.dr);
        m_data_next.green_left  = sub_sat(y0_3_reg, offs.dg);
        m_data_next.blue_left   = add_sat(y0_3_reg, offs.db);
        m_data_next.red_right   = add_sat(y1_3_reg, offs.dr);
        m_data_next.green_right = sub_sat(y1_3_reg, offs.dg);
        m_data_next.blue_right  = add_sat(y1_3_reg, offs.db);
    end

    assign m_valid = out_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== hw/rtl/yuvp_checker.sv =====
// yuvp_checker: port-level assertions for yuv_pair_to_rgb888, with its bind.
// Depends on yuvp_pkg and yuv_pair_to_rgb888.

module yuvp_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input yuvp_pkg::out_item_t m_data
);

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("m_valid high after reset");

    // stalled result transaction holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // with the sink held ready, an accepted transaction is not lost on its way to the output
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) ##1 m_ready ##1 m_ready ##1 m_ready |=> m_valid)
        else $error("accepted transaction lost in pipeline");

endmodule

bind yuv_pair_to_rgb888 yuvp_checker u_yuvp_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

// ===== sim/yuv_pair_to_rgb888_test.sv =====
// yuv_pair_to_rgb888_test: self-checking testbench for the YUV pixel-pair to RGB888 converter.
// Predicts both RGB pixels of every accepted pair and compares them in order with the outputs.
// Depends on yuvp_pkg and the yuv_pair_to_rgb888 RTL.

module yuv_pair_to_rgb888_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HOLD_AFTER   = 300;
    localparam int HOLD_LEN     = 400;
    localparam int PHASES       = 10;
    localparam int PHASE_ITEMS  = 125;
    localparam int SETTLE       = 8;
    localparam int DRAIN_LIMIT  = 20000;

    class pixel_pair_board;
        logic [1:0]          layout;
        yuvp_pkg::out_item_t expected_pixels[$];
        int                  accepted;
        int                  matched;
        int                  errors;

        function new();
            layout   = yuvp_pkg::LAYOUT_YUYV;
            accepted = 0;
            matched  = 0;
            errors   = 0;
        endfunction

        function logic [7:0] clamp8(int v);
            if (v < 0) begin
                return 8'd0;
            end
            if (v > 255) begin
                return 8'd255;
            end
            return v[7:0];
        endfunction

        // floor division by 256 via arithmetic shift of signed ints
        function logic [23:0] rgb_of(int luma, int cu, int cv);
            int r;
            int g;
            int b;
            r = luma + ((359 * cv) >>> 8);
            g = luma - ((88 * cu + 183 * cv) >>> 8);
            b = luma + ((454 * cu) >>> 8);
            return {clamp8(r), clamp8(g), clamp8(b)};
        endfunction

        function yuvp_pkg::out_item_t convert_pair(yuvp_pkg::in_item_t p);
            int y0;
            int y1;
            int cu;
            int cv;
            yuvp_pkg::out_item_t res;
            case (layout)
                yuvp_pkg::LAYOUT_YUYV: begin
                    y0 = p.byte_first;  cu = p.byte_second;
                    y1 = p.byte_third;  cv = p.byte_fourth;
                end
                yuvp_pkg::LAYOUT_UYVY: begin
                    cu = p.byte_first;  y0 = p.byte_second;
                    cv = p.byte_third;  y1 = p.byte_fourth;
                end
                yuvp_pkg::LAYOUT_NV12: begin
                    y0 = p.byte_first;  y1 = p.byte_second;
                    cu = p.byte_third;  cv = p.byte_fourth;
                end
                default: begin
                    y0 = p.byte_first;  y1 = p.byte_second;
                    cv = p.byte_third;  cu = p.byte_fourth;
                end
            endcase
            cu = cu - 128;
            cv = cv - 128;
            {res.red_left, res.green_left, res.blue_left}    = rgb_of(y0, cu, cv);
            {res.red_right, res.green_right, res.blue_right} = rgb_of(y1, cu, cv);
            return res;
        endfunction

        function void note_pair(yuvp_pkg::in_item_t p);
            expected_pixels.push_back(convert_pair(p));
            accepted++;
        endfunction

        function void check_field(string name, logic [7:0] exp_val, logic [7:0] got_val);
            if (got_val !== exp_val) begin
                $error("%s: expected %0d, got %0d", name, exp_val, got_val);
                errors++;
            end
        endfunction

        function void check_pixels(yuvp_pkg::out_item_t got);
            yuvp_pkg::out_item_t want;
            if (expected_pixels.size() == 0) begin
                $error("output transaction with no pending pixel pair");
                errors++;
                return;
            end
            want = expected_pixels.pop_front();
            check_field("red_left", want.red_left, got.red_left);
            check_field("green_left", want.green_left, got.green_left);
            check_field("blue_left", want.blue_left, got.blue_left);
            check_field("red_right", want.red_right, got.red_right);
            check_field("green_right", want.green_right, got.green_right);
            check_field("blue_right", want.blue_right, got.blue_right);
            matched++;
        endfunction
    endclass

    logic                aclk;
    logic                aresetn;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [1:0]          cfg_data;
    logic                s_valid;
    logic                s_ready;
    yuvp_pkg::in_item_t  s_data;
    logic                m_valid;
    logic                m_ready;
    yuvp_pkg::out_item_t m_data;

    pixel_pair_board board;
    int layout_writes;

    yuv_pair_to_rgb888 u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            board.check_pixels(m_data);
        end
    end

    initial begin
        #5_000_000;
        $display("yuv_pair_to_rgb888: mismatch");
        $finish;
    end

    // receiver: random stall segments plus one long hold-off to back up the pipeline
    initial begin
        int  seg_len;
        int  mode;
        int  period;
        int  duty;
        int  cnt;
        bit  rdy;
        bit  hold_done;
        m_ready   = 1'b0;
        hold_done = 1'b0;
        cnt       = 0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            seg_len = $urandom_range(20, 120);
            mode    = $urandom_range(0, 3);
            period  = $urandom_range(2, 20);
            duty    = $urandom_range(1, period - 1);
            repeat (seg_len) begin
                if (!hold_done && board.accepted >= HOLD_AFTER) begin
                    hold_done = 1'b1;
                    repeat (HOLD_LEN) begin
                        m_ready <= 1'b0;
                        @(posedge aclk);
                    end
                end
                case (mode)
                    0: rdy = 1'b1;
                    1: rdy = 1'($urandom_range(0, 1));
                    2: rdy = ($urandom_range(0, 7) != 0);
                    default: rdy = ((cnt % period) < duty);
                endcase
                cnt++;
                m_ready <= rdy;
                @(posedge aclk);
            end
        end
    end

    task automatic send_pair(input yuvp_pkg::in_item_t item);
        s_data  <= item;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        board.note_pair(item);
    endtask

    task automatic write_layout(input logic [1:0] value);
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        board.layout = value;
        layout_writes++;
    endtask

    task automatic wait_drained();
        int waited;
        waited = 0;
        while (board.expected_pixels.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        repeat (SETTLE) @(posedge aclk);
    endtask

    function automatic logic [7:0] edge_byte();
        case ($urandom_range(0, 5))
            0: return 8'd0;
            1: return 8'd1;
            2: return 8'd127;
            3: return 8'd128;
            4: return 8'd254;
            default: return 8'd255;
        endcase
    endfunction

    function automatic yuvp_pkg::in_item_t random_pair();
        yuvp_pkg::in_item_t p;
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 14) begin
            p = $urandom;
        end else if (pick < 17) begin
            p = {edge_byte(), edge_byte(), edge_byte(), edge_byte()};
        end else begin
            // bytes 1 and 3 near mid-scale, bytes 2 and 4 at the rails (neutral chroma, rail luma in UYVY)
            p.byte_first  = 8'($urandom_range(120, 136));
            p.byte_second = $urandom_range(0, 1) ? 8'($urandom_range(0, 8))
                                                 : 8'($urandom_range(247, 255));
            p.byte_third  = 8'($urandom_range(120, 136));
            p.byte_fourth = $urandom_range(0, 1) ? 8'($urandom_range(0, 8))
                                                 : 8'($urandom_range(247, 255));
        end
        return p;
    endfunction

    initial begin
        yuvp_pkg::in_item_t corner_pairs[6];
        int                 burst_left;
        int                 gap;
        logic [1:0]         lay;

        board         = new();
        layout_writes = 0;
        aresetn       = 1'b0;
        cfg_valid     = 1'b0;
        cfg_data      = yuvp_pkg::LAYOUT_YUYV;
        s_valid       = 1'b0;
        s_data        = '0;

        corner_pairs[0] = 32'h0000_0000;
        corner_pairs[1] = 32'hFFFF_FFFF;
        corner_pairs[2] = 32'h00FF_FF00;
        corner_pairs[3] = 32'hFF00_00FF;
        corner_pairs[4] = 32'h8080_8080;
        corner_pairs[5] = 32'h01FE_7F80;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int l = 0; l < 4; l++) begin
            write_layout(l[1:0]);
            foreach (corner_pairs[i]) begin
                send_pair(corner_pairs[i]);
            end
            s_valid <= 1'b0;
            wait_drained();
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            if (ph == 0) begin
                lay = yuvp_pkg::LAYOUT_YUYV;
            end else if (ph == PHASES - 1) begin
                lay = yuvp_pkg::LAYOUT_NV21;
            end else begin
                lay = 2'($urandom_range(0, 3));
            end
            write_layout(lay);
            burst_left = 0;
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 40);
                    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    if (gap != 0) begin
                        s_valid <= 1'b0;
                        repeat (gap) @(posedge aclk);
                    end
                end
                send_pair(random_pair());
                burst_left--;
            end
            s_valid <= 1'b0;
            wait_drained();
        end

        if (board.expected_pixels.size() != 0) begin
            $error("%0d pixel pairs never came out", board.expected_pixels.size());
            board.errors++;
        end
        $display("Converted %0d pixel pairs (%0d checked) across %0d layout writes,",
                 board.accepted, board.matched, layout_writes);
        $display("with random input gaps, output stalls and one long output hold-off.");
        if (board.errors == 0) begin
            $display("yuv_pair_to_rgb888: match");
        end else begin
            $display("yuv_pair_to_rgb888: mismatch");
        end
        $finish;
    end

endmodule
